// ===== hw/rtl/frtd_pkg.sv =====
// package for the frame rate tier degrader
// holds tier codes, register indexes, thresholds and the result beat layout
// no dependencies
package frtd_pkg;

   localparam int FpsW     = 8;
   localparam int GapW     = 10;
   localparam int TierW    = 2;
   localparam int SumW     = 9;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 2;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 16;

   // tier codes
   localparam logic [TierW-1:0] QUALITY_HIGH     = 2'd0;
   localparam logic [TierW-1:0] QUALITY_MID      = 2'd1;
   localparam logic [TierW-1:0] QUALITY_LOW      = 2'd2;
   localparam logic [TierW-1:0] QUALITY_VERY_LOW = 2'd3;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_MONITOR_ENABLE = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_START_TIER     = 2'd1;

   // thresholds
   localparam logic [FpsW-1:0] FPS_HIGH_MEAN  = 8'd65;
   localparam logic [FpsW-1:0] FPS_SAVER_LO   = 8'd28;
   localparam logic [FpsW-1:0] FPS_MEAN_HI    = 8'd34;
   localparam logic [FpsW-1:0] FPS_SAVER_HI   = 8'd33;
   localparam logic [FpsW-1:0] FPS_EXIT       = 8'd45;
   localparam logic [FpsW-1:0] FPS_FLOOR_SAVE = 8'd22;
   localparam logic [FpsW-1:0] FPS_FLOOR_STD  = 8'd40;
   localparam logic [FpsW-1:0] BASE_DEFAULT   = 8'd60;
   localparam logic [FpsW-1:0] BASE_SAVER     = 8'd30;
   localparam logic [GapW-1:0] GAP_LIMIT      = 10'd45;
   localparam logic [1:0]      DOWN_LIMIT     = 2'd3;
   localparam logic [2:0]      GRACE_MAX      = 3'd4;
   localparam logic [2:0]      GRACE_SAMPLE   = 3'd3;

   typedef struct packed {
      logic            active;
      logic [FpsW-1:0] baseline_fps;
      logic            downgraded;
      logic [TierW-1:0] tier;
   } rsp_type;

endpackage

// ===== hw/rtl/frame_rate_tier_degrader.sv =====
// frame rate tier degrader top level
// depends on frtd_pkg
//
// Takes one tick beat per cycle (frame rate and largest frame gap) and returns
// one result beat for every tick, in the cycle after the tick is accepted. The
// whole tracking update (baseline learning, battery-saver hysteresis, low-rate
// counting and tier step-down) is computed combinationally into the state
// registers, and the result sits in an output register, so ticks may arrive
// back to back while the output side keeps taking beats; a stalled output
// holds req_tready low. Register 0 is monitor enable, register 1 the start
// tier, whose write reloads the tier and restarts learning. csr_ready is
// always high; write registers only while no tick is in flight.
module frame_rate_tier_degrader (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // frame_rate [7:0], max_frame_gap [17:8], zero pad [23:18]
   input  logic [frtd_pkg::ReqDataW-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tier [1:0], downgraded [2], baseline_fps [10:3], active [11], zero pad [15:12]
   output logic [frtd_pkg::RspDataW-1:0]  rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [frtd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [frtd_pkg::CsrDataW-1:0]  csr_data
);
   import frtd_pkg::*;

   logic             enable_ff, enable_in;
   logic [TierW-1:0] tier_ff, tier_in;
   logic [FpsW-1:0]  base_ff, base_in;
   logic [2:0]       grace_ff, grace_in;
   logic [SumW-1:0]  sum_ff, sum_in;
   logic [1:0]       scount_ff, scount_in;
   logic             locked_ff, locked_in;
   logic [1:0]       saver_ff, saver_in;
   logic [1:0]       low_ff, low_in;
   logic             rvalid_ff, rvalid_in;
   rsp_type          rsp_ff, rsp_in;

   logic            req_beat, csr_beat;
   logic [FpsW-1:0] fps;
   logic [GapW-1:0] gap;
   logic            act;
   logic            down;
   logic [SumW-1:0] thr_high, thr_lo, thr_hi;
   logic [SumW:0]   sum_round;
   logic [FpsW-1:0] mean;
   logic [FpsW-1:0] base_lock;
   logic [FpsW-1:0] floor_fps;
   logic [1:0]      low_step;

   assign fps        = req_tdata[FpsW-1:0];
   assign gap        = req_tdata[FpsW+GapW-1:FpsW];
   assign req_tready = !rvalid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_beat   = csr_valid;
   assign act        = enable_ff && (tier_ff == QUALITY_HIGH || tier_ff == QUALITY_MID);

   // mean thresholds scaled by the sample count
   assign thr_high  = SumW'({7'd0, scount_ff} * SumW'(FPS_HIGH_MEAN));
   assign thr_lo    = SumW'({7'd0, scount_ff} * SumW'(FPS_SAVER_LO));
   assign thr_hi    = SumW'({7'd0, scount_ff} * SumW'(FPS_MEAN_HI));
   assign sum_round = {1'b0, sum_ff} + (SumW+1)'(1);
   // at most two samples: the rounded mean is the sum or the halved sum
   assign mean      = (scount_ff == 2'd1) ? sum_ff[FpsW-1:0] : sum_round[FpsW:1];

   always_comb begin
      if (sum_ff > thr_high) begin
         base_lock = mean;
      end else if (sum_ff >= thr_lo && sum_ff <= thr_hi && gap < GAP_LIMIT) begin
         base_lock = BASE_SAVER;
      end else begin
         base_lock = BASE_DEFAULT;
      end
   end

   always_comb begin
      enable_in = enable_ff;
      tier_in   = tier_ff;
      base_in   = base_ff;
      grace_in  = grace_ff;
      sum_in    = sum_ff;
      scount_in = scount_ff;
      locked_in = locked_ff;
      saver_in  = saver_ff;
      low_in    = low_ff;
      down      = 1'b0;
      floor_fps = FPS_FLOOR_STD;
      low_step  = 2'd0;

      if (req_beat && act) begin
         if (grace_ff < GRACE_MAX) begin
            grace_in = grace_ff + 3'd1;
         end
         if (grace_in <= GRACE_SAMPLE) begin
            if (grace_in > 3'd1 && fps != '0 && scount_ff < 2'd3) begin
               sum_in    = sum_ff + SumW'(fps);
               scount_in = scount_ff + 2'd1;
            end
         end else begin
            if (scount_ff != 2'd0 && !locked_ff) begin
               base_in   = base_lock;
               locked_in = 1'b1;
            end
            if (base_in >= BASE_DEFAULT && fps >= FPS_SAVER_LO && fps <= FPS_SAVER_HI
                && gap < GAP_LIMIT) begin
               if (saver_ff < 2'd3) begin
                  saver_in = saver_ff + 2'd1;
               end
               if (saver_in >= 2'd2) begin
                  base_in = BASE_SAVER;
                  low_in  = 2'd0;
               end
            end else if (base_in == BASE_SAVER && fps >= FPS_EXIT) begin
               base_in  = (fps > FPS_HIGH_MEAN) ? fps : BASE_DEFAULT;
               low_in   = 2'd0;
               saver_in = 2'd0;
            end else if (base_in >= BASE_DEFAULT) begin
               if (saver_ff != 2'd0) begin
                  saver_in = saver_ff - 2'd1;
               end
            end

            floor_fps = (base_in == BASE_SAVER) ? FPS_FLOOR_SAVE : FPS_FLOOR_STD;
            if (fps < floor_fps) begin
               low_step = low_in + 2'd1;
            end else begin
               low_step = (low_in > 2'd2) ? low_in - 2'd2 : 2'd0;
            end
            low_in = low_step;
            if (low_step >= DOWN_LIMIT) begin
               tier_in = (tier_ff == QUALITY_HIGH) ? QUALITY_MID : QUALITY_LOW;
               down    = 1'b1;
               low_in  = 2'd0;
            end
         end
      end

      if (csr_beat) begin
         if (csr_index == REG_MONITOR_ENABLE) begin
            enable_in = csr_data[0];
         end else if (csr_index == REG_START_TIER) begin
            tier_in   = csr_data[TierW-1:0];
            base_in   = BASE_DEFAULT;
            grace_in  = '0;
            sum_in    = '0;
            scount_in = '0;
            locked_in = 1'b0;
            saver_in  = '0;
            low_in    = '0;
         end
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      rsp_in    = rsp_ff;
      if (req_beat) begin
         rvalid_in           = 1'b1;
         rsp_in.tier         = tier_in;
         rsp_in.downgraded   = down;
         rsp_in.baseline_fps = base_in;
         rsp_in.active       = act;
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         tier_ff   <= QUALITY_HIGH;
         base_ff   <= BASE_DEFAULT;
         grace_ff  <= '0;
         sum_ff    <= '0;
         scount_ff <= '0;
         locked_ff <= 1'b0;
         saver_ff  <= '0;
         low_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         tier_ff   <= tier_in;
         base_ff   <= base_in;
         grace_ff  <= grace_in;
         sum_ff    <= sum_in;
         scount_ff <= scount_in;
         locked_ff <= locked_in;
         saver_ff  <= saver_in;
         low_ff    <= low_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {(RspDataW-$bits(rsp_type))'(0), rsp_ff};

endmodule

// ===== hw/rtl/frtd_checker.sv =====
// port-level checks for the frame rate tier degrader
// depends on frtd_pkg; bound to frame_rate_tier_degrader at the end of the file
module frtd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [frtd_pkg::RspDataW-1:0] rsp_tdata
);
   import frtd_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_tdata[$bits(rsp_type)-1:0];

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // no tick is taken while a result waits
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("tick accepted while output stalled");

   // every accepted tick shows a result next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   // a step-down only from an active tick and only to mid or low
   a_down_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.downgraded |->
         rsp.active && (rsp.tier == QUALITY_MID || rsp.tier == QUALITY_LOW))
      else $error("illegal downgrade report");

endmodule

bind frame_rate_tier_degrader frtd_checker u_frtd_checker (.*);
